// ----- rtl/kth_pkg.sv -----
`timescale 1ns / 1ps

package kth_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed result field widths
  localparam int POS_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int KEY_W       = 32;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TAKE   = 2'd2,
    KIND_DROP   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [KEY_W-1:0]  serial;
  } in_t;

  typedef struct packed {
    logic                     ok;
    logic [POS_W-1:0]         position;
    logic [COUNT_W-1:0]       entry_count;
    logic                     holding;
    logic signed [KEY_W-1:0]  held_serial;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic add;
    logic put_back;
    logic rd_last;
    logic move;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  hit;
    logic  scan_done;
    logic  out_free;
  } status_t;

endpackage

// ----- rtl/keyed_table_with_hold_slot_core.sv -----
`timescale 1ns / 1ps

// Channel  Valid      Stall      Payload
// in       in_valid   in_stall   in_data  (kind, serial)
// out      out_valid  out_stall  out_data (ok, position, entry_count, holding, held_serial)
//
// Lookup and take scan the key store one entry a cycle over the single read
// port of the key store; add and drop skip the scan.
// One request is worked at a time; a new one is taken once the result is
// in the output register, even while that result is stalled.
// rst is synchronous: table empty, hold slot empty, no result pending.

module keyed_table_with_hold_slot_core import kth_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t    cmd;
  status_t status;

  kth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kth_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/kth_datapath.sv -----
`timescale 1ns / 1ps

module kth_datapath import kth_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  output status_t status,
  input  in_t     in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_data
);

  // Key store, one write and one read port, registered read
  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data;

  // Request and table state
  kind_t            kind;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] count;
  logic             hold_valid;
  logic [KEY_W-1:0] hold_key;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_pending;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] found_pos;
  logic             ok;

  logic             full;
  logic [CNT_W-1:0] last;
  logic [IDX_W-1:0] last_idx;
  logic             scan_more;
  logic             hit;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             out_free;

  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign last      = count - CNT_W'(1);
  assign last_idx  = last[IDX_W-1:0];
  assign scan_more = (scan_idx < count);
  assign hit       = rd_pending && (rd_data == key);
  assign out_free  = !out_valid || !out_stall;

  assign status.kind      = kind;
  assign status.hit       = hit;
  assign status.scan_done = !rd_pending && !scan_more;
  assign status.out_free  = out_free;

  // Write port select: append key, append held key, or fill the vacated slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = key;
    if (cmd.add && !full) begin
      wr_en = 1'b1;
    end else if (cmd.put_back && hold_valid && !full) begin
      wr_en   = 1'b1;
      wr_data = hold_key;
    end else if (cmd.move && (found_pos != last_idx)) begin
      wr_en   = 1'b1;
      wr_addr = found_pos;
      wr_data = rd_data;
    end
  end

  // Read port select: scan pointer or last entry
  assign rd_en   = cmd.rd_last || (cmd.scan && scan_more);
  assign rd_addr = cmd.rd_last ? last_idx : scan_idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Table and hold slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      hold_valid <= 1'b0;
      hold_key   <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_pending <= 1'b0;
      end
      if (cmd.scan) begin
        rd_pending <= scan_more;
      end
      if (cmd.add && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.put_back && hold_valid && !full) begin
        count      <= count + CNT_W'(1);
        hold_valid <= 1'b0;
        hold_key   <= '0;
      end
      if (cmd.move) begin
        count      <= last;
        hold_valid <= 1'b1;
        hold_key   <= key;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-request working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind      <= in_data.kind;
      key       <= in_data.serial;
      ok        <= 1'b0;
      scan_idx  <= '0;
      found_pos <= '0;
    end
    if (cmd.scan) begin
      rd_idx <= scan_idx[IDX_W-1:0];
      if (scan_more) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (hit) begin
        found_pos <= rd_idx;
        ok        <= 1'b1;
      end
    end
    if ((cmd.add && !full) || (cmd.put_back && hold_valid && !full) || cmd.move) begin
      ok <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.ok          <= ok;
      out_data.position    <= (kind == KIND_LOOKUP && ok) ? POS_W'(found_pos) : '0;
      out_data.entry_count <= COUNT_W'(count);
      out_data.holding     <= hold_valid;
      out_data.held_serial <= hold_valid ? hold_key : '0;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded over an untaken result");

  a_move_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.move |=> hold_valid && (count == $past(last)))
    else $error("take did not fill hold slot or shrink table");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.add && !full |=> count == $past(count) + CNT_W'(1))
    else $error("add did not grow table");

endmodule

// ----- rtl/kth_ctrl.sv -----
`timescale 1ns / 1ps

module kth_ctrl import kth_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EXEC   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_PUT    = 7'b0001000,
    ST_RDLAST = 7'b0010000,
    ST_MOVE   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != ST_IDLE);

  // Sequencing of one request
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // kind is known from here on; add and drop skip the scan
        if (status.kind == KIND_ADD || status.kind == KIND_DROP) begin
          state_next = ST_EXEC;
        end else begin
          cmd.scan = 1'b1;
          if (status.hit) begin
            state_next = (status.kind == KIND_TAKE) ? ST_PUT : ST_EMIT;
          end else if (status.scan_done) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EXEC: begin
        if (status.kind == KIND_ADD) begin
          cmd.add = 1'b1;
        end else begin
          cmd.put_back = 1'b1;
        end
        state_next = ST_EMIT;
      end
      ST_PUT: begin
        cmd.put_back = 1'b1;
        state_next = ST_RDLAST;
      end
      ST_RDLAST: begin
        cmd.rd_last = 1'b1;
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  a_take_path: assert property (@(posedge clk) disable iff (rst)
    cmd.move |-> $past(cmd.rd_last) && $past(cmd.put_back, 2))
    else $error("swap-remove out of order");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !in_stall)
    else $error("not ready after result");

endmodule

// ----- tb/sv/tb_keyed_table_with_hold_slot_core.sv -----
`timescale 1ns / 1ps

module tb_keyed_table_with_hold_slot_core;
  import kth_pkg::*;

  localparam int N_RANDOM   = 650;
  localparam int HOLD_AFTER = 300;  // requests accepted before the long output hold-off
  localparam int HOLD_LEN   = 200;
  localparam int DRAIN_CYC  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  keyed_table_with_hold_slot_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   total_reqs  = 0;
  int   issued      = 0;
  int   accept_cnt  = 0;
  int   error_cnt   = 0;

  // Predicted table contents and hold slot
  logic [KEY_W-1:0] key_tab[TABLE_DEPTH];
  int               n_keys   = 0;
  bit               held     = 1'b0;
  logic [KEY_W-1:0] held_key = '0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  task automatic queue_req(input kind_t k, input logic [KEY_W-1:0] s);
    in_t r;
    r.kind   = k;
    r.serial = s;
    pending_reqs.push_back(r);
  endtask

  // Updates the predicted table for one request and returns its result
  function automatic out_t apply_request(input in_t req);
    out_t r;
    bit   found;
    int   pos;
    int   last;
    r     = '0;
    found = 1'b0;
    pos   = 0;
    for (int i = 0; i < n_keys; i++) begin
      if (!found && key_tab[i] == req.serial) begin
        found = 1'b1;
        pos   = i;
      end
    end
    case (req.kind)
      KIND_ADD: begin
        if (n_keys < TABLE_DEPTH) begin
          key_tab[n_keys] = req.serial;
          n_keys++;
          r.ok = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (found) begin
          r.ok       = 1'b1;
          r.position = POS_W'(pos);
        end
      end
      KIND_TAKE: begin
        if (found) begin
          // held key goes back first when there is room, else it is lost
          if (held && n_keys < TABLE_DEPTH) begin
            key_tab[n_keys] = held_key;
            n_keys++;
          end
          held     = 1'b1;
          held_key = key_tab[pos];
          last     = n_keys - 1;
          if (pos != last) key_tab[pos] = key_tab[last];
          n_keys = last;
          r.ok   = 1'b1;
        end
      end
      default: begin
        if (held && n_keys < TABLE_DEPTH) begin
          key_tab[n_keys] = held_key;
          n_keys++;
          held     = 1'b0;
          held_key = '0;
          r.ok     = 1'b1;
        end
      end
    endcase
    r.entry_count = COUNT_W'(n_keys);
    r.holding     = held;
    r.held_serial = held ? held_key : '0;
    return r;
  endfunction

  // Request acceptance and result checking at the rising edge
  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request(in_data));
        accept_cnt++;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", got));
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok)
            report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
          if (got.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d",
                                      got.position, want.position));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      got.entry_count, want.entry_count));
          if (got.holding !== want.holding)
            report_mismatch($sformatf("holding %b, want %b",
                                      got.holding, want.holding));
          if (got.held_serial !== want.held_serial)
            report_mismatch($sformatf("held_serial %h, want %h",
                                      got.held_serial, want.held_serial));
        end
      end
    end
  end

  // Request driver: random gaps, with stretches of back-to-back requests
  int tx_gap    = 0;
  bit tx_steady = 1'b0;

  always @(negedge clk) begin
    logic nxt_valid;
    int   r;
    nxt_valid = in_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || accept_cnt == issued) begin
      if (tx_gap > 0) begin
        tx_gap--;
        nxt_valid = 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt_valid = 1'b1;
        in_data <= pending_reqs.pop_front();
        issued++;
        if (issued % 80 == 0) tx_steady = ($urandom_range(0, 2) == 0);
        r = $urandom_range(0, 99);
        if (tx_steady || r < 50) tx_gap = 0;
        else if (r < 90)         tx_gap = $urandom_range(1, 3);
        else                     tx_gap = $urandom_range(6, 25);
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid <= nxt_valid;
  end

  // Result receiver: random stall runs, one long hold-off to back the block up
  int rx_run    = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_cycle  = 0;
  bit rx_steady = 1'b0;

  always @(negedge clk) begin
    int r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 400 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && accept_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (rx_steady) begin
        rx_run = 0;
        out_stall <= 1'b0;
      end else if (rx_run > 0) begin
        rx_run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall <= 1'b0;
          rx_run = $urandom_range(0, 5);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          rx_run = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          rx_run = $urandom_range(8, 30);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [KEY_W-1:0] key_pool[8];
    int               phase;
    int               w_add;
    int               w_take;
    int               r;
    logic [KEY_W-1:0] s;
    kind_t            k;

    for (int i = 0; i < TABLE_DEPTH; i++) key_tab[i] = '0;

    // empty table and empty hold slot
    queue_req(KIND_DROP,   32'h0000_0000);
    queue_req(KIND_LOOKUP, 32'h0000_0005);
    queue_req(KIND_TAKE,   32'h0000_0005);
    // key extremes, with a duplicate
    queue_req(KIND_ADD,    32'h8000_0000);
    queue_req(KIND_ADD,    32'h7FFF_FFFF);
    queue_req(KIND_ADD,    32'h0000_0000);
    queue_req(KIND_ADD,    32'hFFFF_FFFF);
    queue_req(KIND_ADD,    32'h7FFF_FFFF);
    queue_req(KIND_LOOKUP, 32'h7FFF_FFFF);
    queue_req(KIND_TAKE,   32'h7FFF_FFFF);
    // take while holding with room: held key appended, then fills the hole
    queue_req(KIND_TAKE,   32'h8000_0000);
    queue_req(KIND_DROP,   32'h0000_0000);
    queue_req(KIND_DROP,   32'h0000_0000);
    // fill the table, then add to a full table
    for (int i = 0; i < 11; i++) queue_req(KIND_ADD, 32'h5A5A_0000 + i);
    queue_req(KIND_ADD,    32'h0000_0001);
    queue_req(KIND_LOOKUP, 32'h5A5A_000A);
    // take from a full table, refill, then take while holding when full
    queue_req(KIND_TAKE,   32'h0000_0000);
    queue_req(KIND_ADD,    32'h0000_0002);
    queue_req(KIND_TAKE,   32'hFFFF_FFFF);
    queue_req(KIND_DROP,   32'hFFFF_FFFF);
    queue_req(KIND_LOOKUP, 32'h1234_5678);

    // random part: phases lean towards filling, mixing or emptying the table
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0)
        for (int j = 0; j < 8; j++) key_pool[j] = $urandom;
      phase = (i / 50) % 3;
      case (phase)
        0:       begin w_add = 60; w_take = 10; end
        1:       begin w_add = 30; w_take = 25; end
        default: begin w_add = 10; w_take = 50; end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_add)               k = KIND_ADD;
      else if (r < w_add + w_take) k = KIND_TAKE;
      else if (r < 85)             k = KIND_LOOKUP;
      else                         k = KIND_DROP;
      s = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)] : $urandom;
      queue_req(k, s);
    end
    total_reqs = pending_reqs.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accept_cnt < total_reqs || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kth_pkg.sv
rtl/kth_datapath.sv
rtl/kth_ctrl.sv
rtl/keyed_table_with_hold_slot_core.sv
tb/sv/tb_keyed_table_with_hold_slot_core.sv
